FILE: src/sparse_network_eval_argmax_unit_assert.svh
// Assertion helpers used by the top RTL module of the network evaluator.
`ifndef SPARSE_NETWORK_EVAL_ARGMAX_UNIT_ASSERT_SVH
`define SPARSE_NETWORK_EVAL_ARGMAX_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SNE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle rule");

// Next-cycle implication, disabled while reset is held.
`define SNE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle rule");

`endif

FILE: src/sneval_pkg.sv
`default_nettype none

package sneval_pkg;

    // Default sizes of the stores.
    localparam int MAX_NODES      = 64;
    localparam int MAX_LINKS      = 256;
    localparam int SQUASH_ENTRIES = 1024;

    // Fixed field widths.
    localparam int ID_W    = 6;
    localparam int WT_W    = 16;
    localparam int LEVEL_W = 16;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_DEFINE = 2'd0,
        CMD_LINK   = 2'd1,
        CMD_STAGE  = 2'd2,
        CMD_EVAL   = 2'd3
    } t_cmd;

    // Node kinds.
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_SENSOR = 2'd1;
    localparam logic [1:0] KIND_HIDDEN = 2'd2;
    localparam logic [1:0] KIND_OUTPUT = 2'd3;

    // One stored connection; the source is implied by the chain it sits in.
    typedef struct packed {
        logic [ID_W-1:0]        tgt;
        logic signed [WT_W-1:0] wt;
        logic                   en;
    } t_link;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_NODE,
        ST_NCHK,
        ST_LRD,
        ST_LSRC,
        ST_LDST,
        ST_LMUL,
        ST_LACC,
        ST_ONODE,
        ST_OSQ,
        ST_OCMP,
        ST_DONE
    } t_state;

    localparam longint unsigned Q24_ONE = 64'd1 << 24;

    // Unsigned long division by shift and subtract, used only while the
    // sigmoid contents are computed at elaboration.
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Sigmoid level at x = xq/256, built from a Q24 series of e^(|x|/8)
    // squared three times. Evaluated only at elaboration for the ROM.
    function automatic logic [LEVEL_W-1:0] squash_at(input int xq);
        longint unsigned a;
        longint unsigned z;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned den;
        longint unsigned num;
        longint unsigned v;
        a    = longint'(xq < 0 ? -xq : xq);
        z    = a << 13;
        term = Q24_ONE;
        sum  = Q24_ONE;
        for (int n = 1; n <= 24; n++) begin
            term = udiv64((term * z) >> 24, 64'(n));
            sum  = sum + term;
        end
        for (int k = 0; k < 3; k++) begin
            sum = (sum * sum) >> 24;
        end
        den = sum + Q24_ONE;
        num = (xq >= 0 ? sum : Q24_ONE) << 16;
        v   = udiv64(num + (den >> 1), den);
        return (v > 64'd65535) ? 16'hFFFF : v[LEVEL_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/sneval_squash.sv
`default_nettype none

// Sigmoid lookup: clamps a Q16.16 value to [-8, 8), scales it to a table
// index and reads the level ROM into an output register.
module sneval_squash #(
    parameter int SQUASH_ENTRIES = sneval_pkg::SQUASH_ENTRIES
) (
    input  wire logic                              i_clk,
    input  wire logic signed [31:0]                i_value,
    output logic [sneval_pkg::LEVEL_W-1:0]         o_level
);

    localparam int SQW = (SQUASH_ENTRIES > 1) ? $clog2(SQUASH_ENTRIES) : 1;
    localparam int PW  = 21 + SQW;

    logic [sneval_pkg::LEVEL_W-1:0] w_rom [SQUASH_ENTRIES];
    logic [19:0]                    w_off;
    logic [PW-1:0]                  w_scaled;
    logic [SQW-1:0]                 w_idx;
    logic [sneval_pkg::LEVEL_W-1:0] r_level;

    // Constant sigmoid contents, one entry per step of the input range.
    for (genvar g = 0; g < SQUASH_ENTRIES; g++) begin : g_rom
        localparam int XQ = (g * 4096) / SQUASH_ENTRIES - 2048;
        localparam logic [sneval_pkg::LEVEL_W-1:0] LV = sneval_pkg::squash_at(XQ);
        assign w_rom[g] = LV;
    end

    // Clamp and offset into [0, 2^20); flipping the sign bit adds 8.0.
    always_comb begin
        if (i_value < -32'sd524288) begin
            w_off = 20'h00000;
        end else if (i_value > 32'sd524287) begin
            w_off = 20'hFFFFF;
        end else begin
            w_off = i_value[19:0] ^ 20'h80000;
        end
    end

    // Index is floor(offset * entries / 2^20).
    assign w_scaled = PW'(w_off) * PW'(SQUASH_ENTRIES);
    assign w_idx    = w_scaled[20 +: SQW];

    // Registered ROM read.
    always_ff @(posedge i_clk) begin
        r_level <= w_rom[w_idx];
    end

    assign o_level = r_level;

endmodule

`default_nettype wire

FILE: src/sparse_network_eval_argmax_unit.sv
`default_nettype none

// Sparse feed-forward network evaluator with argmax readout.
// Command channel: an item is taken at a clock edge with start high and
// busy low. Define-node and stage-value commands complete in the idle state
// and leave busy low. Add-connection does the kind and chain-tail lookup, then
// the append in the add state. Evaluate holds busy until its single result is out.
// Result channel: o_valid is high for exactly one cycle with the winner id,
// its sigmoid level, the no-output flag and the sticky overflow flag. The
// receiver cannot stall it; only evaluate produces a beat.
// Evaluation walks the sensor nodes, then the hidden nodes, and visits every
// chained connection of a firing node through the states LRD, LSRC, LDST,
// LMUL and LACC; it then scans the output nodes and ends with the result beat.
// Each connection does a read-modify-write of the node sum memory through
// the sigmoid ROM and the multiplier.
// Connections are kept in per-source chains (head, tail and next pointers),
// so only links of firing nodes are visited, in the order they were added.
// Reset clears node kinds, sums, staged values and chain heads through valid
// bits and clears the link count and overflow flag; there is no clearing pass.
module sparse_network_eval_argmax_unit #(
    parameter int MAX_NODES      = sneval_pkg::MAX_NODES,
    parameter int MAX_LINKS      = sneval_pkg::MAX_LINKS,
    parameter int SQUASH_ENTRIES = sneval_pkg::SQUASH_ENTRIES
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [1:0]                           i_command,
    input  wire logic [sneval_pkg::ID_W-1:0]          i_node_id,
    input  wire logic [1:0]                           i_node_kind,
    input  wire logic [sneval_pkg::ID_W-1:0]          i_target_id,
    input  wire logic signed [sneval_pkg::WT_W-1:0]   i_weight,
    input  wire logic                                 i_enabled,
    input  wire logic signed [15:0]                   i_sensor_value,
    output logic                                      o_valid,
    output logic [sneval_pkg::ID_W-1:0]               o_winner_id,
    output logic [sneval_pkg::LEVEL_W-1:0]            o_winner_level,
    output logic                                      o_no_outputs,
    output logic                                      o_table_overflow
);

    `include "sparse_network_eval_argmax_unit_assert.svh"

    localparam int NW = $clog2(MAX_NODES);
    localparam int LW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
    localparam int CW = $clog2(MAX_LINKS + 1) + 1;

    sneval_pkg::t_state r_state, n_state;

    // Storage.
    logic [1:0]              kind_mem [MAX_NODES];
    logic signed [31:0]      sum_mem  [MAX_NODES];
    logic signed [15:0]      stg_mem  [MAX_NODES];
    logic [LW-1:0]           head_mem [MAX_NODES];
    logic [LW-1:0]           tail_mem [MAX_NODES];
    sneval_pkg::t_link       link_mem [MAX_LINKS];
    logic [LW-1:0]           next_mem [MAX_LINKS];

    logic [MAX_NODES-1:0]    r_kind_v;
    logic [MAX_NODES-1:0]    r_sum_v;
    logic [MAX_NODES-1:0]    r_stg_v;
    logic [MAX_NODES-1:0]    r_hv;

    // Memory read data.
    logic [1:0]              r_kind_q;
    logic                    r_kind_vq;
    logic signed [31:0]      r_sum_q;
    logic                    r_sum_vq;
    logic signed [15:0]      r_stg_q;
    logic                    r_stg_vq;
    logic [LW-1:0]           r_head_q;
    logic [LW-1:0]           r_tail_q;
    sneval_pkg::t_link       r_link_q;
    logic [LW-1:0]           r_next_q;

    // Sequencer registers.
    logic [CW-1:0]           r_count;
    logic                    r_ovf;
    logic [NW-1:0]           r_add_id;
    logic                    r_add_id_ok;
    sneval_pkg::t_link       r_add_link;
    logic [NW-1:0]           r_node;
    logic                    r_pass;
    logic [LW-1:0]           r_cur;
    logic [LW-1:0]           r_last;
    sneval_pkg::t_link       r_link;
    logic [LW-1:0]           r_next;
    logic                    r_dst_ok;
    logic signed [31:0]      r_dsum;
    logic signed [31:0]      r_prod;
    logic                    r_is_out;
    logic                    r_found;
    logic [NW-1:0]           r_best_id;
    logic [sneval_pkg::LEVEL_W-1:0] r_best_lv;

    // Combinational signals.
    logic                    w_accept;
    logic [NW-1:0]           w_id_idx;
    logic                    w_id_ok;
    logic [NW-1:0]           w_kind_ra;
    logic [NW-1:0]           w_ht_ra;
    logic [NW-1:0]           w_sum_ra;
    logic [1:0]              w_kind_eff;
    logic signed [31:0]      w_sum_eff;
    logic signed [31:0]      w_sensor;
    logic signed [31:0]      w_sq_in;
    logic [sneval_pkg::LEVEL_W-1:0] w_level;
    logic                    w_src_ok;
    logic                    w_full;
    logic                    w_match;
    logic                    w_node_last;
    logic                    w_chain_end;
    logic [NW-1:0]           w_dst_idx;
    logic                    w_dst_in;
    logic signed [32:0]      w_mul;
    logic signed [32:0]      w_acc;
    logic signed [31:0]      w_sat;
    logic                    w_better;

    assign w_accept    = start && !busy;
    assign w_id_idx    = NW'(i_node_id);
    assign w_id_ok     = 32'(i_node_id) < 32'(MAX_NODES);
    assign w_kind_eff  = r_kind_vq ? r_kind_q : sneval_pkg::KIND_NONE;
    assign w_sum_eff   = r_sum_vq ? r_sum_q : 32'sd0;
    assign w_sensor    = r_stg_vq ? {{8{r_stg_q[15]}}, r_stg_q, 8'd0} : 32'sd0;
    assign w_src_ok    = r_add_id_ok && (w_kind_eff == sneval_pkg::KIND_SENSOR
                                      || w_kind_eff == sneval_pkg::KIND_HIDDEN);
    assign w_full      = r_count >= CW'(MAX_LINKS);
    assign w_match     = r_hv[r_node] && (w_kind_eff == (r_pass ? sneval_pkg::KIND_HIDDEN
                                                                 : sneval_pkg::KIND_SENSOR));
    assign w_node_last = r_node == NW'(MAX_NODES - 1);
    assign w_chain_end = r_cur == r_last;
    assign w_dst_idx   = NW'(r_link.tgt);
    assign w_dst_in    = 32'(r_link.tgt) < 32'(MAX_NODES);
    assign w_sq_in     = (r_state == sneval_pkg::ST_OSQ || r_pass) ? w_sum_eff : w_sensor;

    // Product Q4.28, floored to Q16.16 and added with saturation.
    assign w_mul = $signed(r_link.wt) * $signed({1'b0, w_level});
    assign w_acc = 33'(r_dsum) + 33'(r_prod >>> 12);
    always_comb begin
        if (w_acc > 33'sd2147483647) begin
            w_sat = 32'sh7FFFFFFF;
        end else if (w_acc < -33'sd2147483648) begin
            w_sat = 32'sh80000000;
        end else begin
            w_sat = w_acc[31:0];
        end
    end
    assign w_better = r_is_out && (!r_found || w_level > r_best_lv);

    sneval_squash #(
        .SQUASH_ENTRIES(SQUASH_ENTRIES)
    ) u_squash (
        .i_clk   (i_clk),
        .i_value (w_sq_in),
        .o_level (w_level)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sneval_pkg::ST_IDLE: begin
                if (w_accept && i_command == sneval_pkg::CMD_LINK) begin
                    n_state = sneval_pkg::ST_ADD;
                end else if (w_accept && i_command == sneval_pkg::CMD_EVAL) begin
                    n_state = sneval_pkg::ST_NODE;
                end
            end
            sneval_pkg::ST_ADD:   n_state = sneval_pkg::ST_IDLE;
            sneval_pkg::ST_NODE:  n_state = sneval_pkg::ST_NCHK;
            sneval_pkg::ST_NCHK: begin
                if (w_match) begin
                    n_state = sneval_pkg::ST_LRD;
                end else if (w_node_last && r_pass) begin
                    n_state = sneval_pkg::ST_ONODE;
                end else begin
                    n_state = sneval_pkg::ST_NODE;
                end
            end
            sneval_pkg::ST_LRD:   n_state = sneval_pkg::ST_LSRC;
            sneval_pkg::ST_LSRC:  n_state = sneval_pkg::ST_LDST;
            sneval_pkg::ST_LDST:  n_state = sneval_pkg::ST_LMUL;
            sneval_pkg::ST_LMUL:  n_state = sneval_pkg::ST_LACC;
            sneval_pkg::ST_LACC: begin
                if (!w_chain_end) begin
                    n_state = sneval_pkg::ST_LRD;
                end else if (w_node_last && r_pass) begin
                    n_state = sneval_pkg::ST_ONODE;
                end else begin
                    n_state = sneval_pkg::ST_NODE;
                end
            end
            sneval_pkg::ST_ONODE: n_state = sneval_pkg::ST_OSQ;
            sneval_pkg::ST_OSQ:   n_state = sneval_pkg::ST_OCMP;
            sneval_pkg::ST_OCMP: begin
                n_state = w_node_last ? sneval_pkg::ST_DONE : sneval_pkg::ST_ONODE;
            end
            sneval_pkg::ST_DONE:  n_state = sneval_pkg::ST_IDLE;
            default:              n_state = sneval_pkg::ST_IDLE;
        endcase
    end

    // State-driven outputs and memory read addresses.
    always_comb begin
        busy      = r_state != sneval_pkg::ST_IDLE;
        o_valid   = r_state == sneval_pkg::ST_DONE;
        w_kind_ra = r_node;
        w_sum_ra  = r_node;
        w_ht_ra   = r_node;
        case (r_state)
            sneval_pkg::ST_IDLE: begin
                w_kind_ra = w_id_idx;
                w_ht_ra   = w_id_idx;
            end
            sneval_pkg::ST_LSRC: w_kind_ra = NW'(r_link_q.tgt);
            sneval_pkg::ST_LDST: w_sum_ra  = w_dst_idx;
            default: ;
        endcase
    end

    assign o_winner_id      = sneval_pkg::ID_W'(r_best_id);
    assign o_winner_level   = r_best_lv;
    assign o_no_outputs     = !r_found;
    assign o_table_overflow = r_ovf;

    // Node kind memory.
    always_ff @(posedge i_clk) begin
        if (r_state == sneval_pkg::ST_IDLE && w_accept
                && i_command == sneval_pkg::CMD_DEFINE && w_id_ok) begin
            kind_mem[w_id_idx] <= i_node_kind;
        end
        r_kind_q  <= kind_mem[w_kind_ra];
        r_kind_vq <= r_kind_v[w_kind_ra];
    end

    // Node sum memory; read before each accumulate, written after it.
    always_ff @(posedge i_clk) begin
        if (r_state == sneval_pkg::ST_LACC && r_dst_ok) begin
            sum_mem[w_dst_idx] <= w_sat;
        end
        r_sum_q  <= sum_mem[w_sum_ra];
        r_sum_vq <= r_sum_v[w_sum_ra];
    end

    // Staged sensor value memory.
    always_ff @(posedge i_clk) begin
        if (w_accept && i_command == sneval_pkg::CMD_STAGE && w_id_ok) begin
            stg_mem[w_id_idx] <= i_sensor_value;
        end
        r_stg_q  <= stg_mem[r_node];
        r_stg_vq <= r_stg_v[r_node];
    end

    // Chain head and tail per source node.
    always_ff @(posedge i_clk) begin
        if (r_state == sneval_pkg::ST_ADD && w_src_ok && !w_full) begin
            tail_mem[r_add_id] <= r_count[LW-1:0];
            if (!r_hv[r_add_id]) begin
                head_mem[r_add_id] <= r_count[LW-1:0];
            end
        end
        r_head_q <= head_mem[w_ht_ra];
        r_tail_q <= tail_mem[w_ht_ra];
    end

    // Link table and chain pointers.
    always_ff @(posedge i_clk) begin
        if (r_state == sneval_pkg::ST_ADD && w_src_ok && !w_full) begin
            link_mem[r_count[LW-1:0]] <= r_add_link;
            if (r_hv[r_add_id]) begin
                next_mem[r_tail_q] <= r_count[LW-1:0];
            end
        end
        r_link_q <= link_mem[r_cur];
        r_next_q <= next_mem[r_cur];
    end

    // Payload registers of the add command and of the walk.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_add_id    <= w_id_idx;
            r_add_id_ok <= w_id_ok;
            r_add_link  <= '{tgt: i_target_id, wt: i_weight, en: i_enabled};
        end
        if (r_state == sneval_pkg::ST_NCHK) begin
            r_cur  <= r_head_q;
            r_last <= r_tail_q;
        end
        if (r_state == sneval_pkg::ST_LACC) begin
            r_cur <= r_next;
        end
        if (r_state == sneval_pkg::ST_LSRC) begin
            r_link <= r_link_q;
            r_next <= r_next_q;
        end
        if (r_state == sneval_pkg::ST_LDST) begin
            r_dst_ok <= r_link.en && w_dst_in
                     && (w_kind_eff inside {sneval_pkg::KIND_HIDDEN, sneval_pkg::KIND_OUTPUT});
        end
        if (r_state == sneval_pkg::ST_LMUL) begin
            r_dsum <= w_sum_eff;
            r_prod <= w_mul[31:0];
        end
        if (r_state == sneval_pkg::ST_OSQ) begin
            r_is_out <= w_kind_eff == sneval_pkg::KIND_OUTPUT;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sneval_pkg::ST_IDLE;
            r_kind_v  <= '0;
            r_sum_v   <= '0;
            r_stg_v   <= '0;
            r_hv      <= '0;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_node    <= '0;
            r_pass    <= 1'b0;
            r_found   <= 1'b0;
            r_best_id <= '0;
            r_best_lv <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                sneval_pkg::ST_IDLE: begin
                    if (w_accept && i_command == sneval_pkg::CMD_DEFINE && w_id_ok) begin
                        r_kind_v[w_id_idx] <= 1'b1;
                    end
                    if (w_accept && i_command == sneval_pkg::CMD_STAGE && w_id_ok) begin
                        r_stg_v[w_id_idx] <= 1'b1;
                    end
                    if (w_accept && i_command == sneval_pkg::CMD_EVAL) begin
                        r_sum_v   <= '0;
                        r_node    <= '0;
                        r_pass    <= 1'b0;
                        r_found   <= 1'b0;
                        r_best_id <= '0;
                        r_best_lv <= '0;
                    end
                end
                sneval_pkg::ST_ADD: begin
                    if (w_src_ok && w_full) begin
                        r_ovf <= 1'b1;
                    end else if (w_src_ok) begin
                        r_hv[r_add_id] <= 1'b1;
                        r_count        <= r_count + CW'(1);
                    end
                end
                sneval_pkg::ST_NCHK: begin
                    if (!w_match) begin
                        r_node <= w_node_last ? '0 : r_node + NW'(1);
                        if (w_node_last) begin
                            r_pass <= 1'b1;
                        end
                    end
                end
                sneval_pkg::ST_LACC: begin
                    if (r_dst_ok) begin
                        r_sum_v[w_dst_idx] <= 1'b1;
                    end
                    if (w_chain_end) begin
                        r_node <= w_node_last ? '0 : r_node + NW'(1);
                        if (w_node_last) begin
                            r_pass <= 1'b1;
                        end
                    end
                end
                sneval_pkg::ST_OCMP: begin
                    if (w_better) begin
                        r_best_id <= r_node;
                        r_best_lv <= w_level;
                    end
                    if (r_is_out) begin
                        r_found <= 1'b1;
                    end
                    r_node <= w_node_last ? '0 : r_node + NW'(1);
                end
                sneval_pkg::ST_DONE: begin
                    r_stg_v <= '0;
                end
                default: ;
            endcase
        end
    end

    `SNE_ASSERT_NEXT(a_eval_holds_busy, i_clk, i_rst_n, w_accept && i_command == sneval_pkg::CMD_EVAL, busy)
    `SNE_ASSERT_IMPLY(a_count_bounded, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_LINKS))
    `SNE_ASSERT_NEXT(a_single_beat, i_clk, i_rst_n, o_valid, !o_valid)
    `SNE_ASSERT_NEXT(a_overflow_sticky, i_clk, i_rst_n, r_ovf, r_ovf)

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sneval_pkg::*;

    // One evaluation result as seen on the result ports.
    typedef struct {
        logic [5:0]  winner;
        logic [15:0] level;
        logic        no_out;
        logic        ovf;
    } t_verdict;

    // Mirror of the network plus the queue of pending evaluation verdicts.
    class network_scoreboard;
        logic [1:0]         kinds[64];
        int                 sums[64];
        logic signed [15:0] staged[64];
        logic [5:0]         link_src[256];
        logic [5:0]         link_dst[256];
        logic signed [15:0] link_wt[256];
        logic               link_en[256];
        int                 link_cnt;
        logic               ovf_flag;
        logic [15:0]        sigmoid_rom[1024];
        t_verdict           pending[$];
        int                 errors;

        function new();
            longint unsigned z, term, acc, den, num, v;
            int xq, mag;
            for (int i = 0; i < 64; i++) begin
                kinds[i]  = KIND_NONE;
                sums[i]   = 0;
                staged[i] = 0;
            end
            link_cnt = 0;
            ovf_flag = 0;
            errors   = 0;
            // Sigmoid table from a Q24 series of e^(|x|/8), squared three times.
            for (int i = 0; i < 1024; i++) begin
                xq   = (i * 4096) / 1024 - 2048;
                mag  = xq < 0 ? -xq : xq;
                z    = longint'(mag) << 13;
                term = 64'd1 << 24;
                acc  = 64'd1 << 24;
                for (int n = 1; n <= 24; n++) begin
                    term = ((term * z) >> 24) / longint'(n);
                    acc  = acc + term;
                end
                for (int k = 0; k < 3; k++) begin
                    acc = (acc * acc) >> 24;
                end
                den = acc + (64'd1 << 24);
                num = (xq >= 0 ? acc : (64'd1 << 24)) << 16;
                v   = (num + den / 2) / den;
                sigmoid_rom[i] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
            end
        endfunction

        function logic [15:0] level_of(int val);
            int c;
            c = val;
            if (c < -524288) c = -524288;
            if (c > 524287) c = 524287;
            return sigmoid_rom[(c + 524288) >>> 10];
        endfunction

        function void propagate(int src, bit from_sensor);
            logic [1:0] tk;
            longint     prod, tot;
            for (int k = 0; k < link_cnt; k++) begin
                if (link_src[k] != src || !link_en[k]) continue;
                tk = kinds[link_dst[k]];
                if (tk != KIND_HIDDEN && tk != KIND_OUTPUT) continue;
                prod = longint'(link_wt[k]) * longint'(level_of(
                    from_sensor ? int'(staged[src]) * 256 : sums[src]));
                tot = longint'(sums[link_dst[k]]) + (prod >>> 12);
                if (tot > 64'sd2147483647) tot = 64'sd2147483647;
                if (tot < -64'sd2147483648) tot = -64'sd2147483648;
                sums[link_dst[k]] = int'(tot);
            end
        endfunction

        // Apply one accepted command beat and queue its verdict, if any.
        function void note_command(t_cmd cmd, logic [5:0] id, logic [1:0] kind,
                                   logic [5:0] tgt, logic signed [15:0] wt,
                                   logic en, logic signed [15:0] sv);
            t_verdict   vd;
            logic [15:0] lv;
            bit          found;
            case (cmd)
                CMD_DEFINE: kinds[id] = kind;
                CMD_LINK: begin
                    if (kinds[id] == KIND_SENSOR || kinds[id] == KIND_HIDDEN) begin
                        if (link_cnt >= 256) begin
                            ovf_flag = 1;
                        end else begin
                            link_src[link_cnt] = id;
                            link_dst[link_cnt] = tgt;
                            link_wt[link_cnt]  = wt;
                            link_en[link_cnt]  = en;
                            link_cnt++;
                        end
                    end
                end
                CMD_STAGE: staged[id] = sv;
                CMD_EVAL: begin
                    foreach (sums[i]) sums[i] = 0;
                    for (int i = 0; i < 64; i++)
                        if (kinds[i] == KIND_SENSOR) propagate(i, 1);
                    for (int i = 0; i < 64; i++)
                        if (kinds[i] == KIND_HIDDEN) propagate(i, 0);
                    found     = 0;
                    vd.winner = 0;
                    vd.level  = 0;
                    for (int i = 0; i < 64; i++) begin
                        if (kinds[i] == KIND_OUTPUT) begin
                            lv = level_of(sums[i]);
                            if (!found || lv > vd.level) begin
                                vd.winner = 6'(i);
                                vd.level  = lv;
                            end
                            found = 1;
                        end
                    end
                    foreach (staged[i]) staged[i] = 0;
                    vd.no_out = !found;
                    vd.ovf    = ovf_flag;
                    pending   = {pending, vd};
                end
                default: ;
            endcase
        endfunction

        // Compare one result beat with the oldest pending verdict.
        function void check_verdict(t_verdict got);
            t_verdict want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: id %0d level %0d",
                             got.winner, got.level);
                return;
            end
            want = pending.pop_front();
            if (got.winner !== want.winner || got.level !== want.level ||
                got.no_out !== want.no_out || got.ovf !== want.ovf) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                             want.winner, want.level, want.no_out, want.ovf,
                             got.winner, got.level, got.no_out, got.ovf);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_command;
    logic [5:0]         i_node_id;
    logic [1:0]         i_node_kind;
    logic [5:0]         i_target_id;
    logic signed [15:0] i_weight;
    logic               i_enabled;
    logic signed [15:0] i_sensor_value;
    logic               o_valid;
    logic [5:0]         o_winner_id;
    logic [15:0]        o_winner_level;
    logic               o_no_outputs;
    logic               o_table_overflow;

    network_scoreboard sb;
    int                gap_pct;

    sparse_network_eval_argmax_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_node_id        (i_node_id),
        .i_node_kind      (i_node_kind),
        .i_target_id      (i_target_id),
        .i_weight         (i_weight),
        .i_enabled        (i_enabled),
        .i_sensor_value   (i_sensor_value),
        .o_valid          (o_valid),
        .o_winner_id      (o_winner_id),
        .o_winner_level   (o_winner_level),
        .o_no_outputs     (o_no_outputs),
        .o_table_overflow (o_table_overflow)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Result beats are taken at the rising edge that ends their cycle.
    always @(posedge i_clk) begin
        t_verdict got;
        if (i_rst_n && o_valid) begin
            got.winner = o_winner_id;
            got.level  = o_winner_level;
            got.no_out = o_no_outputs;
            got.ovf    = o_table_overflow;
            sb.check_verdict(got);
        end
    end

    // Present one command beat from a falling edge and hold it until taken.
    task automatic send(t_cmd cmd, logic [5:0] id, logic [1:0] kind, logic [5:0] tgt,
                        logic signed [15:0] wt, logic en, logic signed [15:0] sv);
        while ($urandom_range(99) < gap_pct) begin
            start = 0;
            @(negedge i_clk);
        end
        i_command      = cmd;
        i_node_id      = id;
        i_node_kind    = kind;
        i_target_id    = tgt;
        i_weight       = wt;
        i_enabled      = en;
        i_sensor_value = sv;
        start          = 1;
        do @(posedge i_clk); while (busy);
        sb.note_command(cmd, id, kind, tgt, wt, en, sv);
        @(negedge i_clk);
    endtask

    // Mostly ids from a small pool so that links and kinds meet each other.
    function automatic logic [5:0] pick_id();
        return ($urandom_range(99) < 80) ? 6'($urandom_range(15)) : 6'($urandom);
    endfunction

    task automatic random_beat();
        int r;
        r = $urandom_range(99);
        if (r < 20)
            send(CMD_DEFINE, pick_id(), ($urandom_range(9) == 0) ? KIND_NONE
                 : 2'($urandom_range(1, 3)), 6'($urandom), 16'($urandom), 1'($urandom),
                 16'($urandom));
        else if (r < 45)
            send(CMD_LINK, pick_id(), 2'($urandom), pick_id(), 16'($urandom),
                 ($urandom_range(4) != 0), 16'($urandom));
        else if (r < 85)
            send(CMD_STAGE, pick_id(), 2'($urandom), 6'($urandom), 16'($urandom),
                 1'($urandom), 16'($urandom));
        else
            send(CMD_EVAL, 6'($urandom), 2'($urandom), 6'($urandom), 16'($urandom),
                 1'($urandom), 16'($urandom));
    endtask

    initial begin
        sb             = new();
        gap_pct        = 0;
        i_rst_n        = 0;
        start          = 0;
        i_command      = CMD_DEFINE;
        i_node_id      = 0;
        i_node_kind    = KIND_NONE;
        i_target_id    = 0;
        i_weight       = 0;
        i_enabled      = 0;
        i_sensor_value = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1;

        // Directed: no outputs, extreme ids and values, bad sources,
        // self and backward links, redefinition and undefining.
        send(CMD_EVAL, 0, 0, 0, 0, 0, 0);
        send(CMD_DEFINE, 0, KIND_SENSOR, 0, 0, 0, 0);
        send(CMD_DEFINE, 63, KIND_SENSOR, 0, 0, 0, 0);
        send(CMD_DEFINE, 5, KIND_HIDDEN, 0, 0, 0, 0);
        send(CMD_DEFINE, 20, KIND_HIDDEN, 0, 0, 0, 0);
        send(CMD_DEFINE, 10, KIND_OUTPUT, 0, 0, 0, 0);
        send(CMD_DEFINE, 62, KIND_OUTPUT, 0, 0, 0, 0);
        send(CMD_LINK, 0, 0, 5, -16'sd32768, 1, 0);
        send(CMD_LINK, 63, 0, 10, 16'sd32767, 1, 0);
        send(CMD_LINK, 5, 0, 5, 16'sd4096, 1, 0);
        send(CMD_LINK, 5, 0, 62, 16'sd20000, 1, 0);
        send(CMD_LINK, 20, 0, 5, -16'sd9000, 1, 0);
        send(CMD_LINK, 10, 0, 62, 16'sd5000, 1, 0);
        send(CMD_LINK, 33, 0, 62, 16'sd5000, 1, 0);
        send(CMD_LINK, 0, 0, 62, 16'sd30000, 0, 0);
        send(CMD_LINK, 0, 0, 63, 16'sd30000, 1, 0);
        send(CMD_STAGE, 0, 0, 0, 0, 0, 16'sd32767);
        send(CMD_STAGE, 63, 0, 0, 0, 0, -16'sd32768);
        send(CMD_STAGE, 10, 0, 0, 0, 0, 16'sd1234);
        send(CMD_EVAL, 0, 0, 0, 0, 0, 0);
        send(CMD_EVAL, 63, 3, 63, -1, 1, -1);
        send(CMD_DEFINE, 5, KIND_OUTPUT, 0, 0, 0, 0);
        send(CMD_DEFINE, 63, KIND_NONE, 0, 0, 0, 0);
        send(CMD_STAGE, 0, 0, 0, 0, 0, -16'sd700);
        send(CMD_EVAL, 0, 0, 0, 0, 0, 0);

        // Random traffic in three phases of sender gaps.
        for (int n = 0; n < 1500; n++) begin
            gap_pct = (n < 500) ? 21 : (n < 1000) ? 78 : 0;
            random_beat();
        end
        start = 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial begin
        #32ms;
        $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire
